[src/conv3x3_abs_clamp_stream_defines.svh]
// ----------------------------------------------------------------------------
// conv3x3_abs_clamp_stream assertion macros
// shared property templates, sampled on clk and disabled while rst_n is low
// ----------------------------------------------------------------------------
`ifndef CONV3X3_ABS_CLAMP_STREAM_DEFINES_SVH
`define CONV3X3_ABS_CLAMP_STREAM_DEFINES_SVH

// same-cycle implication
`define C3AC_ASSERT_IMPLY(label, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) \
        else $error("%m: implication check failed");

// next-cycle implication
`define C3AC_ASSERT_NEXT(label, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |=> (rhs)) \
        else $error("%m: next-cycle check failed");

`endif

[src/c3ac_pkg.sv]
// ----------------------------------------------------------------------------
// c3ac_pkg
// shared types, constants and helpers of the 3x3 convolution stream
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package c3ac_pkg;

    localparam int DEF_MAX_LINE  = 1024;
    localparam int DEF_COEF_BITS = 8;
    localparam int COEF_BITS_MAX = 16;

    localparam int IMG_W_BITS   = 11;
    localparam int IMG_H_BITS   = 13;
    localparam int HEIGHT_MAX   = 4096;
    localparam int DEF_WIDTH    = 640;
    localparam int DEF_HEIGHT   = 480;
    localparam int PIX_BITS     = 8;
    localparam int CFG_IDX_BITS = 3;

    localparam logic [PIX_BITS-1:0] PIX_MAX = 8'd255;

    // register indexes
    localparam logic [CFG_IDX_BITS-1:0] REG_MASK_TOP   = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_MASK_MID   = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_MASK_BOT   = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_IMG_WIDTH  = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] REG_IMG_HEIGHT = 3'd4;

    // item opcodes
    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_FLUSH = 1'b1;

    // control of one item between the counter stage and the convolution stage
    typedef struct packed {
        logic                drop;
        logic                restart;
        logic                emit;
        logic                done;
        logic                col_zero;
        logic                col_one;
        logic                w_one;
        logic                top_en;
        logic                mid_en;
        logic [PIX_BITS-1:0] bot;
    } s1_ctl_t;

    // one mask row of the horizontal edge operator: -mul, 0, +mul
    function automatic logic [3*COEF_BITS_MAX-1:0] sobel_row(input int bits, input int frac,
                                                             input int mul);
        logic [COEF_BITS_MAX-1:0]   pos;
        logic [COEF_BITS_MAX-1:0]   neg;
        logic [3*COEF_BITS_MAX-1:0] row;
        pos = COEF_BITS_MAX'(mul << frac);
        neg = -pos;
        row = '0;
        for (int i = 0; i < bits; i++)
        begin
            row[i]          = neg[i];
            row[2*bits + i] = pos[i];
        end
        return row;
    endfunction

endpackage

[src/c3ac_ram.sv]
// ----------------------------------------------------------------------------
// c3ac_ram
// simple dual-port RAM, one write and one registered read per cycle
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module c3ac_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024,
    localparam int AddrW = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AddrW-1:0] wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AddrW-1:0] rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[src/c3ac_line_buf.sv]
// ----------------------------------------------------------------------------
// c3ac_line_buf
// two line stores (previous row, row before) with write-to-read forwarding
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module c3ac_line_buf #(
    parameter int MAX_LINE = c3ac_pkg::DEF_MAX_LINE,
    localparam int ColW = $clog2(MAX_LINE)
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          rd_en,
    input  logic [ColW-1:0]               rd_addr,
    input  logic                          wr_en,
    input  logic [ColW-1:0]               wr_addr,
    input  logic [c3ac_pkg::PIX_BITS-1:0] wr_a,
    output logic [c3ac_pkg::PIX_BITS-1:0] a_q,
    output logic [c3ac_pkg::PIX_BITS-1:0] b_q
);

    logic [c3ac_pkg::PIX_BITS-1:0] ram_a_q;
    logic [c3ac_pkg::PIX_BITS-1:0] ram_b_q;
    logic                          fwd_reg;
    logic                          fwd_next;
    logic [c3ac_pkg::PIX_BITS-1:0] fwd_a_reg;
    logic [c3ac_pkg::PIX_BITS-1:0] fwd_b_reg;

    c3ac_ram #(
        .WIDTH (c3ac_pkg::PIX_BITS),
        .DEPTH (MAX_LINE)
    ) u_store_a (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_a),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (ram_a_q)
    );

    c3ac_ram #(
        .WIDTH (c3ac_pkg::PIX_BITS),
        .DEPTH (MAX_LINE)
    ) u_store_b (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (a_q),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (ram_b_q)
    );

    // a read that meets a write to the same column sees the new data
    assign fwd_next = rd_en ? (wr_en && (wr_addr == rd_addr)) : fwd_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fwd_reg <= 1'b0;
        end
        else
        begin
            fwd_reg <= fwd_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            fwd_a_reg <= wr_a;
            fwd_b_reg <= a_q;
        end
    end

    assign a_q = fwd_reg ? fwd_a_reg : ram_a_q;
    assign b_q = fwd_reg ? fwd_b_reg : ram_b_q;

endmodule

[src/c3ac_ctrl.sv]
// ----------------------------------------------------------------------------
// c3ac_ctrl
// configuration registers, frame counters and the stage register of each item
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module c3ac_ctrl #(
    parameter int MAX_LINE  = c3ac_pkg::DEF_MAX_LINE,
    parameter int COEF_BITS = c3ac_pkg::DEF_COEF_BITS,
    localparam int ColW    = $clog2(MAX_LINE),
    localparam int RowBits = 3 * COEF_BITS,
    localparam int CfgW    = (RowBits > c3ac_pkg::IMG_H_BITS) ? RowBits : c3ac_pkg::IMG_H_BITS
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_write,
    input  logic [c3ac_pkg::CFG_IDX_BITS-1:0] cfg_index,
    input  logic [CfgW-1:0]                   cfg_data,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic                              opcode,
    input  logic [c3ac_pkg::PIX_BITS-1:0]     pixel,
    input  logic                              s1_adv,
    output logic                              s1_valid,
    output c3ac_pkg::s1_ctl_t                 s1_ctl,
    output logic [ColW-1:0]                   s1_col,
    output logic [ColW-1:0]                   rd_addr,
    output logic                              rd_en,
    output logic [RowBits-1:0]                mask_top,
    output logic [RowBits-1:0]                mask_mid,
    output logic [RowBits-1:0]                mask_bot
);

    localparam int WW      = ColW + 1;
    localparam int HW      = c3ac_pkg::IMG_H_BITS;
    localparam int WRegW   = c3ac_pkg::IMG_W_BITS;
    localparam int WCmpW   = (WW > WRegW) ? WW : WRegW;
    localparam int CntW    = ColW + $clog2(c3ac_pkg::HEIGHT_MAX);
    localparam int TotW    = WW + HW;
    localparam int CoefFrac = COEF_BITS / 2;

    localparam logic [RowBits-1:0] SobelOuter =
        RowBits'(c3ac_pkg::sobel_row(COEF_BITS, CoefFrac, 1));
    localparam logic [RowBits-1:0] SobelMid =
        RowBits'(c3ac_pkg::sobel_row(COEF_BITS, CoefFrac, 2));

    logic [RowBits-1:0] mask_top_reg;
    logic [RowBits-1:0] mask_mid_reg;
    logic [RowBits-1:0] mask_bot_reg;
    logic [WRegW-1:0]   width_reg;
    logic [HW-1:0]      height_reg;

    logic [ColW-1:0] col_reg;
    logic [ColW-1:0] col_next;
    logic [HW-1:0]   row_reg;
    logic [HW-1:0]   row_next;
    logic [CntW-1:0] cnt_reg;
    logic [CntW-1:0] cnt_next;
    logic            s1_valid_reg;
    logic            s1_valid_next;

    c3ac_pkg::s1_ctl_t s1_ctl_reg;
    c3ac_pkg::s1_ctl_t s1_ctl_next;
    logic [ColW-1:0]   s1_col_reg;

    logic [WCmpW-1:0] width_ext;
    logic [WW-1:0]    w_val;
    logic [HW-1:0]    h_val;
    logic [TotW-1:0]  total;
    logic [TotW-1:0]  total_m1;
    logic             accept;
    logic             wrap_pre;
    logic [ColW-1:0]  col_a;
    logic [HW-1:0]    row_a;
    logic             restart;
    logic [ColW-1:0]  c;
    logic [HW-1:0]    r;
    logic [CntW-1:0]  cnt;
    logic             in_frame;
    logic             drop;
    logic             emit;
    logic             done;
    logic [WW-1:0]    c_inc;
    logic             c_wrap;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_top_reg <= SobelOuter;
            mask_mid_reg <= SobelMid;
            mask_bot_reg <= SobelOuter;
            width_reg    <= WRegW'(c3ac_pkg::DEF_WIDTH);
            height_reg   <= HW'(c3ac_pkg::DEF_HEIGHT);
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                c3ac_pkg::REG_MASK_TOP:   mask_top_reg <= cfg_data[RowBits-1:0];
                c3ac_pkg::REG_MASK_MID:   mask_mid_reg <= cfg_data[RowBits-1:0];
                c3ac_pkg::REG_MASK_BOT:   mask_bot_reg <= cfg_data[RowBits-1:0];
                c3ac_pkg::REG_IMG_WIDTH:  width_reg    <= cfg_data[WRegW-1:0];
                c3ac_pkg::REG_IMG_HEIGHT: height_reg   <= cfg_data[HW-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // clamped frame size
    assign width_ext = WCmpW'(width_reg);

    always_comb
    begin
        if (width_ext == '0)
        begin
            w_val = WW'(1);
        end
        else if (width_ext > WCmpW'(MAX_LINE))
        begin
            w_val = WW'(MAX_LINE);
        end
        else
        begin
            w_val = WW'(width_ext);
        end

        if (height_reg == '0)
        begin
            h_val = HW'(1);
        end
        else if (height_reg > HW'(c3ac_pkg::HEIGHT_MAX))
        begin
            h_val = HW'(c3ac_pkg::HEIGHT_MAX);
        end
        else
        begin
            h_val = height_reg;
        end
    end

    assign total    = TotW'(w_val) * TotW'(h_val);
    assign total_m1 = total - TotW'(1);

    assign in_ready = !s1_valid_reg || s1_adv;
    assign accept   = in_valid && in_ready;

    // position of this item, after a size change while idle
    assign wrap_pre = WW'(col_reg) >= w_val;
    assign col_a    = wrap_pre ? '0 : col_reg;
    assign row_a    = wrap_pre ? HW'(row_reg + HW'(1)) : row_reg;
    assign restart  = ((HW + 1)'(row_a) > ((HW + 1)'(h_val) + (HW + 1)'(1)))
                   || (TotW'(cnt_reg) >= total);
    assign c        = restart ? '0 : col_a;
    assign r        = restart ? '0 : row_a;
    assign cnt      = restart ? '0 : cnt_reg;

    assign in_frame = r < h_val;
    assign drop     = in_frame && (opcode == c3ac_pkg::OP_FLUSH);
    assign emit     = !drop && ((r >= HW'(2)) || ((r == HW'(1)) && (c != '0)));
    assign done     = emit && (TotW'(cnt) == total_m1);
    assign c_inc    = WW'(c) + WW'(1);
    assign c_wrap   = c_inc >= w_val;

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        cnt_next = cnt_reg;
        if (accept)
        begin
            if (drop)
            begin
                col_next = c;
                row_next = r;
                cnt_next = cnt;
            end
            else if (done)
            begin
                col_next = '0;
                row_next = '0;
                cnt_next = '0;
            end
            else
            begin
                if (c_wrap)
                begin
                    col_next = '0;
                    row_next = HW'(r + HW'(1));
                end
                else
                begin
                    col_next = ColW'(c_inc);
                    row_next = r;
                end
                cnt_next = emit ? CntW'(cnt + CntW'(1)) : cnt;
            end
        end
    end

    always_comb
    begin
        s1_ctl_next.drop     = drop;
        s1_ctl_next.restart  = restart;
        s1_ctl_next.emit     = emit;
        s1_ctl_next.done     = done;
        s1_ctl_next.col_zero = (c == '0);
        s1_ctl_next.col_one  = (c == ColW'(1));
        s1_ctl_next.w_one    = (w_val == WW'(1));
        s1_ctl_next.top_en   = r >= HW'(2);
        s1_ctl_next.mid_en   = r >= HW'(1);
        s1_ctl_next.bot      = in_frame ? pixel : '0;
    end

    assign s1_valid_next = accept ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg      <= '0;
            row_reg      <= '0;
            cnt_reg      <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            col_reg      <= col_next;
            row_reg      <= row_next;
            cnt_reg      <= cnt_next;
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_ctl_reg <= s1_ctl_next;
            s1_col_reg <= c;
        end
    end

    assign s1_valid = s1_valid_reg;
    assign s1_ctl   = s1_ctl_reg;
    assign s1_col   = s1_col_reg;
    assign rd_addr  = c;
    assign rd_en    = accept;
    assign mask_top = mask_top_reg;
    assign mask_mid = mask_mid_reg;
    assign mask_bot = mask_bot_reg;

endmodule

[src/c3ac_conv.sv]
// ----------------------------------------------------------------------------
// c3ac_conv
// 3x3 window, nine-tap multiply-accumulate, magnitude clamp and result register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module c3ac_conv #(
    parameter int COEF_BITS = c3ac_pkg::DEF_COEF_BITS,
    localparam int RowBits = 3 * COEF_BITS
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s1_valid,
    input  c3ac_pkg::s1_ctl_t             s1_ctl,
    input  logic [c3ac_pkg::PIX_BITS-1:0] top_raw,
    input  logic [c3ac_pkg::PIX_BITS-1:0] mid_raw,
    input  logic [RowBits-1:0]            mask_top,
    input  logic [RowBits-1:0]            mask_mid,
    input  logic [RowBits-1:0]            mask_bot,
    output logic                          s1_adv,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [c3ac_pkg::PIX_BITS-1:0] filtered,
    output logic                          frame_end
);

    localparam int PB       = c3ac_pkg::PIX_BITS;
    localparam int CoefFrac = COEF_BITS / 2;
    localparam int ProdW    = COEF_BITS + PB + 1;
    localparam int SumW     = ProdW + 4;

    logic [PB-1:0] win1_reg [3];
    logic [PB-1:0] win1_next [3];
    logic [PB-1:0] win2_reg [3];
    logic [PB-1:0] win2_next [3];
    logic [PB-1:0] old1 [3];
    logic [PB-1:0] old2 [3];
    logic [PB-1:0] fresh [3];
    logic [PB-1:0] tap [3][3];

    logic [RowBits-1:0]          rows [3];
    logic signed [COEF_BITS-1:0] coef [3][3];
    logic signed [PB:0]          px9 [3][3];
    logic signed [ProdW-1:0]     prod [3][3];
    logic signed [SumW-1:0]      rsum [3];
    logic signed [SumW-1:0]      sum;
    logic [SumW-1:0]             mag;
    logic [SumW-1:0]             scaled;
    logic [PB-1:0]               result;
    logic                        zero_left;

    logic          out_valid_reg;
    logic          out_valid_next;
    logic [PB-1:0] filtered_reg;
    logic          frame_end_reg;

    assign s1_adv = s1_valid && (!s1_ctl.emit || !out_valid_reg || out_ready);

    assign fresh[0] = s1_ctl.top_en ? top_raw : '0;
    assign fresh[1] = s1_ctl.mid_en ? mid_raw : '0;
    assign fresh[2] = s1_ctl.bot;

    assign rows[0] = mask_top;
    assign rows[1] = mask_mid;
    assign rows[2] = mask_bot;

    // left neighbor outside the frame
    assign zero_left = s1_ctl.col_one || (s1_ctl.col_zero && s1_ctl.w_one);

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            old1[i]   = s1_ctl.restart ? '0 : win1_reg[i];
            old2[i]   = s1_ctl.restart ? '0 : win2_reg[i];
            tap[i][0] = zero_left ? '0 : old1[i];
            tap[i][1] = old2[i];
            tap[i][2] = s1_ctl.col_zero ? '0 : fresh[i];
            for (int j = 0; j < 3; j++)
            begin
                coef[i][j] = rows[i][j*COEF_BITS +: COEF_BITS];
                px9[i][j]  = signed'({1'b0, tap[i][j]});
                prod[i][j] = coef[i][j] * px9[i][j];
            end
            rsum[i] = SumW'(prod[i][0]) + SumW'(prod[i][1]) + SumW'(prod[i][2]);
        end
    end

    assign sum    = rsum[0] + rsum[1] + rsum[2];
    assign mag    = sum[SumW-1] ? -sum : sum;
    assign scaled = mag >> CoefFrac;
    assign result = (scaled > SumW'(c3ac_pkg::PIX_MAX)) ? c3ac_pkg::PIX_MAX : PB'(scaled);

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            win1_next[i] = win1_reg[i];
            win2_next[i] = win2_reg[i];
            if (s1_adv)
            begin
                if (s1_ctl.drop)
                begin
                    win1_next[i] = old1[i];
                    win2_next[i] = old2[i];
                end
                else if (s1_ctl.done)
                begin
                    win1_next[i] = '0;
                    win2_next[i] = '0;
                end
                else
                begin
                    win1_next[i] = old2[i];
                    win2_next[i] = fresh[i];
                end
            end
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (s1_adv && s1_ctl.emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 3; i++)
            begin
                win1_reg[i] <= '0;
                win2_reg[i] <= '0;
            end
            out_valid_reg <= 1'b0;
        end
        else
        begin
            for (int i = 0; i < 3; i++)
            begin
                win1_reg[i] <= win1_next[i];
                win2_reg[i] <= win2_next[i];
            end
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv && s1_ctl.emit)
        begin
            filtered_reg  <= result;
            frame_end_reg <= s1_ctl.done;
        end
    end

    assign out_valid = out_valid_reg;
    assign filtered  = filtered_reg;
    assign frame_end = frame_end_reg;

endmodule

[src/conv3x3_abs_clamp_stream.sv]
// ----------------------------------------------------------------------------
// conv3x3_abs_clamp_stream
// streaming 3x3 convolution of grayscale pixels with magnitude and clamp
// ----------------------------------------------------------------------------
// The block takes one transaction per clock and keeps that rate for as long as
// the result side keeps up: every item passes once through a counter stage, a
// stage register and a result register, and its result (if any) is offered
// from the result register. The nine-tap multiply-accumulate is combinational,
// and the one read plus one write per line store and cycle set that rate. The
// result of a pixel comes out after image_width+1 further items; after the last
// pixel of a frame, image_width+1 flush items drain the final row. The line
// stores need no clearing pass after reset.
`timescale 1ns / 1ps

`include "conv3x3_abs_clamp_stream_defines.svh"

module conv3x3_abs_clamp_stream #(
    parameter int MAX_LINE  = c3ac_pkg::DEF_MAX_LINE,
    parameter int COEF_BITS = c3ac_pkg::DEF_COEF_BITS,
    localparam int RowBits = 3 * COEF_BITS,
    localparam int CfgW    = (RowBits > c3ac_pkg::IMG_H_BITS) ? RowBits : c3ac_pkg::IMG_H_BITS
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_write,
    input  logic [c3ac_pkg::CFG_IDX_BITS-1:0] cfg_index,
    input  logic [CfgW-1:0]                   cfg_data,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic                              opcode,
    input  logic [c3ac_pkg::PIX_BITS-1:0]     pixel,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [c3ac_pkg::PIX_BITS-1:0]     filtered,
    output logic                              frame_end
);

    localparam int ColW = $clog2(MAX_LINE);

    logic                          s1_valid;
    c3ac_pkg::s1_ctl_t             s1_ctl;
    logic [ColW-1:0]               s1_col;
    logic                          s1_adv;
    logic [ColW-1:0]               rd_addr;
    logic                          rd_en;
    logic                          wr_en;
    logic [c3ac_pkg::PIX_BITS-1:0] top_raw;
    logic [c3ac_pkg::PIX_BITS-1:0] mid_raw;
    logic [RowBits-1:0]            mask_top;
    logic [RowBits-1:0]            mask_mid;
    logic [RowBits-1:0]            mask_bot;

    c3ac_ctrl #(
        .MAX_LINE  (MAX_LINE),
        .COEF_BITS (COEF_BITS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .opcode    (opcode),
        .pixel     (pixel),
        .s1_adv    (s1_adv),
        .s1_valid  (s1_valid),
        .s1_ctl    (s1_ctl),
        .s1_col    (s1_col),
        .rd_addr   (rd_addr),
        .rd_en     (rd_en),
        .mask_top  (mask_top),
        .mask_mid  (mask_mid),
        .mask_bot  (mask_bot)
    );

    assign wr_en = s1_adv && !s1_ctl.drop;

    c3ac_line_buf #(
        .MAX_LINE (MAX_LINE)
    ) u_line_buf (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .wr_en   (wr_en),
        .wr_addr (s1_col),
        .wr_a    (s1_ctl.bot),
        .a_q     (mid_raw),
        .b_q     (top_raw)
    );

    c3ac_conv #(
        .COEF_BITS (COEF_BITS)
    ) u_conv (
        .clk       (clk),
        .rst_n     (rst_n),
        .s1_valid  (s1_valid),
        .s1_ctl    (s1_ctl),
        .top_raw   (top_raw),
        .mid_raw   (mid_raw),
        .mask_top  (mask_top),
        .mask_mid  (mask_mid),
        .mask_bot  (mask_bot),
        .s1_adv    (s1_adv),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .filtered  (filtered),
        .frame_end (frame_end)
    );

    // an accepted transaction always occupies the stage register next cycle
    `C3AC_ASSERT_NEXT(a_accept_fills_stage, in_valid && in_ready, s1_valid)
    // a result item held in the stage only waits on a stalled output register
    `C3AC_ASSERT_IMPLY(a_stage_stall_cause, s1_valid && s1_ctl.emit && !s1_adv,
                       out_valid && !out_ready)
    // frame completion only on an item that produces a result
    `C3AC_ASSERT_IMPLY(a_done_emits, s1_valid && s1_ctl.done, s1_ctl.emit && !s1_ctl.drop)

endmodule
